FILE: design/cnfc_pkg.sv
// Package for the CNF clause conditioning block.
// Holds payload words, request and assignment codes, controller types and defaults.
// No dependencies.
package cnfc_pkg;

	localparam int NUM_VARS_DEF       = 65536;
	localparam int MAX_CLAUSE_LEN_DEF = 32;
	localparam int VAR_W              = 16;
	localparam int TBL_DEPTH_MAX      = 65536;
	localparam int VAR_LIM_W          = 25;

	localparam logic [1:0] REQ_UNIT  = 2'd0;
	localparam logic [1:0] REQ_LIT   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] ASG_NONE = 2'd0;
	localparam logic [1:0] ASG_POS  = 2'd1;
	localparam logic [1:0] ASG_NEG  = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [VAR_W-1:0] var_index;
		logic             negated;
		logic             clause_end;
	} req_word_t;

	typedef struct packed {
		logic [VAR_W-1:0] out_var;
		logic             out_negated;
		logic             run_last;
		logic             empty_clause;
		logic             too_long;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_UNIT,
		ST_LIT,
		ST_FIN,
		ST_EREAD,
		ST_EOUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_UNIT,
		OUT_EMPTY,
		OUT_LIT
	} out_sel_t;

	typedef struct packed {
		logic     take_item;
		logic     sweep_start;
		logic     sweep_step;
		logic     tbl_unit_wr;
		logic     lit_eval;
		logic     clause_clear;
		logic     emit_next;
		out_sel_t out_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] in_req;
		logic       sweep_done;
		logic       unit_ok;
		logic       item_end;
		logic       satisfied;
		logic       cnt_zero;
		logic       emit_last;
		logic       out_free;
	} dp_sts_t;

endpackage

FILE: design/cnfc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module cnfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/cnfc_ctrl.sv
// Controller state machine of the CNF clause conditioning block.
// Depends on cnfc_pkg; drives the datapath commands from its status.
module cnfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  cnfc_pkg::dp_sts_t sts,
	output cnfc_pkg::ctrl_cmd_t cmd
);

	cnfc_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnfc_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cnfc_pkg::ST_SWEEP: begin
				if (sts.sweep_done) state_d = cnfc_pkg::ST_IDLE;
			end
			cnfc_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (sts.in_req)
						cnfc_pkg::REQ_UNIT:  state_d = cnfc_pkg::ST_UNIT;
						cnfc_pkg::REQ_LIT:   state_d = cnfc_pkg::ST_LIT;
						cnfc_pkg::REQ_CLEAR: state_d = cnfc_pkg::ST_SWEEP;
						default:             state_d = cnfc_pkg::ST_IDLE;
					endcase
				end
			end
			cnfc_pkg::ST_UNIT: begin
				if (!sts.unit_ok || sts.out_free) state_d = cnfc_pkg::ST_IDLE;
			end
			cnfc_pkg::ST_LIT: begin
				state_d = sts.item_end ? cnfc_pkg::ST_FIN : cnfc_pkg::ST_IDLE;
			end
			cnfc_pkg::ST_FIN: begin
				if (sts.satisfied) begin
					state_d = cnfc_pkg::ST_IDLE;
				end else if (sts.cnt_zero) begin
					if (sts.out_free) state_d = cnfc_pkg::ST_IDLE;
				end else begin
					state_d = cnfc_pkg::ST_EREAD;
				end
			end
			cnfc_pkg::ST_EREAD: begin
				state_d = cnfc_pkg::ST_EOUT;
			end
			cnfc_pkg::ST_EOUT: begin
				if (sts.out_free) begin
					state_d = sts.emit_last ? cnfc_pkg::ST_IDLE : cnfc_pkg::ST_EREAD;
				end
			end
			default: state_d = cnfc_pkg::ST_SWEEP;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_sel = cnfc_pkg::OUT_NONE;
		req_stall = (state_q != cnfc_pkg::ST_IDLE);
		case (state_q)
			cnfc_pkg::ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
			end
			cnfc_pkg::ST_IDLE: begin
				cmd.take_item = req_valid;
				cmd.sweep_start = req_valid && (sts.in_req == cnfc_pkg::REQ_CLEAR);
			end
			cnfc_pkg::ST_UNIT: begin
				if (sts.unit_ok && sts.out_free) begin
					cmd.tbl_unit_wr = 1'b1;
					cmd.out_sel = cnfc_pkg::OUT_UNIT;
				end
			end
			cnfc_pkg::ST_LIT: begin
				cmd.lit_eval = 1'b1;
			end
			cnfc_pkg::ST_FIN: begin
				if (sts.satisfied) begin
					cmd.clause_clear = 1'b1;
				end else if (sts.cnt_zero && sts.out_free) begin
					cmd.out_sel = cnfc_pkg::OUT_EMPTY;
					cmd.clause_clear = 1'b1;
				end
			end
			cnfc_pkg::ST_EREAD: begin
				cmd = '0;
			end
			cnfc_pkg::ST_EOUT: begin
				if (sts.out_free) begin
					cmd.out_sel = cnfc_pkg::OUT_LIT;
					cmd.emit_next = 1'b1;
					cmd.clause_clear = sts.emit_last;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: design/cnfc_dp.sv
// Datapath of the CNF clause conditioning block: assignment table, clause
// buffer, clause state and output register. Depends on cnfc_pkg and cnfc_ram.
module cnfc_dp #(
	parameter int NUM_VARS       = cnfc_pkg::NUM_VARS_DEF,
	parameter int MAX_CLAUSE_LEN = cnfc_pkg::MAX_CLAUSE_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cnfc_pkg::req_word_t   req_word,
	input  cnfc_pkg::ctrl_cmd_t   cmd,
	output cnfc_pkg::dp_sts_t     sts,
	input  logic                  res_stall,
	output logic                  res_valid,
	output cnfc_pkg::res_word_t   res_word
);

	localparam int TBL_DEPTH = (NUM_VARS + 1 < cnfc_pkg::TBL_DEPTH_MAX) ?
		NUM_VARS + 1 : cnfc_pkg::TBL_DEPTH_MAX;
	localparam int TAW = $clog2(TBL_DEPTH);
	localparam int CW  = $clog2(MAX_CLAUSE_LEN + 1);
	localparam int BAW = $clog2(MAX_CLAUSE_LEN);
	localparam int BW  = cnfc_pkg::VAR_W + 1;
	localparam logic [cnfc_pkg::VAR_LIM_W-1:0] VAR_LIM = NUM_VARS[cnfc_pkg::VAR_LIM_W-1:0];
	localparam logic [TAW-1:0] SWEEP_LAST = TAW'(TBL_DEPTH - 1);
	localparam logic [CW-1:0]  CNT_MAX    = CW'(MAX_CLAUSE_LEN);

	cnfc_pkg::req_word_t item_q;
	cnfc_pkg::res_word_t res_q;
	logic                res_valid_q;
	logic [TAW-1:0]      sweep_q;
	logic [CW-1:0]       cnt_q;
	logic [BAW-1:0]      idx_q;
	logic                sat_q;
	logic                ovf_q;

	logic                tbl_we;
	logic [TAW-1:0]      tbl_waddr;
	logic [1:0]          tbl_wdata;
	logic [1:0]          tbl_rdata;
	logic                buf_we;
	logic [BW-1:0]       buf_rdata;
	logic                item_ok;
	logic [1:0]          item_asg;
	logic [1:0]          lit_val;
	logic                out_free;

	assign item_ok = (item_q.var_index != '0) &&
		({{(cnfc_pkg::VAR_LIM_W - cnfc_pkg::VAR_W){1'b0}}, item_q.var_index} <= VAR_LIM);
	assign item_asg = item_q.negated ? cnfc_pkg::ASG_NEG : cnfc_pkg::ASG_POS;
	assign lit_val  = item_ok ? tbl_rdata : cnfc_pkg::ASG_NONE;
	assign out_free = !res_valid_q || !res_stall;

	// Table writes come from the clearing sweep or from a unit request.
	always_comb begin
		tbl_we    = cmd.sweep_step || cmd.tbl_unit_wr;
		tbl_waddr = cmd.sweep_step ? sweep_q : item_q.var_index[TAW-1:0];
		tbl_wdata = cmd.sweep_step ? cnfc_pkg::ASG_NONE : item_asg;
	end

	cnfc_ram #(.WIDTH(2), .DEPTH(TBL_DEPTH)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (req_word.var_index[TAW-1:0]),
		.rdata (tbl_rdata)
	);

	assign buf_we = cmd.lit_eval && !sat_q && (lit_val == cnfc_pkg::ASG_NONE) &&
		(cnt_q < CNT_MAX);

	cnfc_ram #(.WIDTH(BW), .DEPTH(MAX_CLAUSE_LEN)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q[BAW-1:0]),
		.wdata ({item_q.var_index, item_q.negated}),
		.raddr (idx_q),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_q <= req_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_start) begin
			sweep_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_q <= sweep_q + TAW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			sat_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (cmd.clause_clear) begin
			cnt_q <= '0;
			idx_q <= '0;
			sat_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.lit_eval && !sat_q) begin
				if (lit_val == cnfc_pkg::ASG_NONE) begin
					if (cnt_q < CNT_MAX) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end else if (lit_val == item_asg) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.emit_next) begin
				idx_q <= idx_q + BAW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_sel != cnfc_pkg::OUT_NONE) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_sel)
			cnfc_pkg::OUT_UNIT: begin
				res_q.out_var      <= item_q.var_index;
				res_q.out_negated  <= item_q.negated;
				res_q.run_last     <= 1'b1;
				res_q.empty_clause <= 1'b0;
				res_q.too_long     <= 1'b0;
			end
			cnfc_pkg::OUT_EMPTY: begin
				res_q.out_var      <= '0;
				res_q.out_negated  <= 1'b0;
				res_q.run_last     <= 1'b1;
				res_q.empty_clause <= 1'b1;
				res_q.too_long     <= 1'b0;
			end
			cnfc_pkg::OUT_LIT: begin
				res_q.out_var      <= buf_rdata[BW-1:1];
				res_q.out_negated  <= buf_rdata[0];
				res_q.run_last     <= sts.emit_last;
				res_q.empty_clause <= 1'b0;
				res_q.too_long     <= ovf_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	always_comb begin
		sts.in_req     = req_word.req_type;
		sts.sweep_done = (sweep_q == SWEEP_LAST);
		sts.unit_ok    = item_ok;
		sts.item_end   = item_q.clause_end;
		sts.satisfied  = sat_q;
		sts.cnt_zero   = (cnt_q == '0);
		sts.emit_last  = ((CW'(idx_q) + CW'(1)) == cnt_q);
		sts.out_free   = out_free;
	end

endmodule

FILE: design/cnf_clause_conditioning.sv
// Top level of the CNF clause conditioning block.
// Depends on cnfc_pkg, cnfc_ctrl and cnfc_dp (which holds two cnfc_ram instances).
//
// This block conditions a stream of CNF clauses on unit literals. Each request
// word carries a unit assignment, a clause literal with an end-of-clause mark,
// or a request to clear the assignment table. A unit on a valid variable is
// recorded in the table and echoed as a one-literal clause. Clause literals
// whose variable is unassigned are buffered; a literal that agrees with the
// table satisfies its clause, which then emits nothing. At the clause end an
// unsatisfied clause is emitted as a run of its buffered literals, one result
// word each, with run_last on the final one, or as a single empty-clause word
// if nothing is left. Literals beyond MAX_CLAUSE_LEN are dropped and too_long
// is set on every word of that run. The block handles one request word at a
// time. A unit is taken and then written in a state of its own; a clause
// literal is taken while its assignment table read is issued and is judged in
// the literal state. A clause end adds a finishing state, and each emitted
// literal a clause buffer read and an output state, as the reads of the table
// and the clause buffer are registered. After a clear request is taken the
// input stays stalled while a sweep writes every table entry, and after reset
// the same sweep runs before the first word is accepted. A finished result
// sits in an output register, so a stall on the result side does not hold up
// the next request until another result has to be produced.
module cnf_clause_conditioning #(
	parameter int NUM_VARS       = cnfc_pkg::NUM_VARS_DEF,
	parameter int MAX_CLAUSE_LEN = cnfc_pkg::MAX_CLAUSE_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  cnfc_pkg::req_word_t req_word,
	output logic                res_valid,
	input  logic                res_stall,
	output cnfc_pkg::res_word_t res_word
);

	// Commands from the controller to the datapath, and status back.
	cnfc_pkg::ctrl_cmd_t cmd;
	cnfc_pkg::dp_sts_t   sts;

	cnfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cnfc_dp #(
		.NUM_VARS       (NUM_VARS),
		.MAX_CLAUSE_LEN (MAX_CLAUSE_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.cmd       (cmd),
		.sts       (sts),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

endmodule

FILE: design/cnfc_checker.sv
// Port-level checker for the CNF clause conditioning block, bound to the top level.
// Depends on cnfc_pkg.
module cnfc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input cnfc_pkg::req_word_t req_word,
	input logic                res_valid,
	input logic                res_stall,
	input cnfc_pkg::res_word_t res_word
);

	// A stalled result word stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// An empty-clause word carries no literal and closes its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.empty_clause |->
			res_word.out_var == '0 && res_word.run_last && !res_word.too_long)
		else $error("malformed empty-clause word");

	// An accepted clear starts the table sweep, so the input is stalled next.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.req_type == cnfc_pkg::REQ_CLEAR |=> req_stall)
		else $error("input not stalled after clear request");

	// An accepted clause literal needs the table read before the next word.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.req_type == cnfc_pkg::REQ_LIT |=> req_stall)
		else $error("input not stalled after clause literal");

endmodule

bind cnf_clause_conditioning cnfc_checker u_cnfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_word  (req_word),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);

FILE: bench/cnfc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the CNF clause conditioning block: watches both handshakes,
// predicts the result words from the accepted request words and compares them in order.
// Depends on cnfc_pkg.
module cnfc_result_checker
	import cnfc_pkg::*;
#(
	parameter int NUM_VARS = NUM_VARS_DEF,
	parameter int MAX_LEN  = MAX_CLAUSE_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_word_t req_word,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_word_t res_word,
	output int        mismatches,
	output int        pending,
	output int        checked
);

	logic [1:0]     asg_tbl [0:TBL_DEPTH_MAX-1];
	logic [VAR_W:0] held_lits [0:MAX_LEN-1];
	int             held_count;
	bit             clause_sat;
	bit             clause_ovf;
	res_word_t      due_results [$];

	initial begin
		foreach (asg_tbl[i]) asg_tbl[i] = ASG_NONE;
		held_count = 0;
		clause_sat = 1'b0;
		clause_ovf = 1'b0;
		mismatches = 0;
		pending    = 0;
		checked    = 0;
	end

	function automatic res_word_t result_of(logic [VAR_W-1:0] v, logic n, logic last,
			logic empty, logic ovf);
		res_word_t r;
		r.out_var      = v;
		r.out_negated  = n;
		r.run_last     = last;
		r.empty_clause = empty;
		r.too_long     = ovf;
		return r;
	endfunction

	function automatic bit var_ok(logic [VAR_W-1:0] v);
		return v != '0 && int'(v) <= NUM_VARS;
	endfunction

	// Appends one predicted word at the tail of the expected queue.
	task automatic queue_result(input res_word_t r);
		due_results.insert(due_results.size(), r);
	endtask

	task automatic condition_word(input req_word_t w);
		logic [1:0] seen;
		case (w.req_type)
			REQ_CLEAR: begin
				foreach (asg_tbl[i]) asg_tbl[i] = ASG_NONE;
			end
			REQ_UNIT: begin
				if (var_ok(w.var_index)) begin
					asg_tbl[w.var_index] = w.negated ? ASG_NEG : ASG_POS;
					queue_result(result_of(w.var_index, w.negated, 1'b1, 1'b0, 1'b0));
				end
			end
			REQ_LIT: begin
				// Once satisfied, the rest of the clause is not looked at.
				if (!clause_sat) begin
					seen = var_ok(w.var_index) ? asg_tbl[w.var_index] : ASG_NONE;
					if (seen == ASG_NONE) begin
						if (held_count < MAX_LEN) begin
							held_lits[held_count] = {w.var_index, w.negated};
							held_count++;
						end else begin
							clause_ovf = 1'b1;
						end
					end else if (seen == (w.negated ? ASG_NEG : ASG_POS)) begin
						clause_sat = 1'b1;
					end
				end
				if (w.clause_end) begin
					if (!clause_sat && held_count == 0) begin
						queue_result(result_of('0, 1'b0, 1'b1, 1'b1, 1'b0));
					end else if (!clause_sat) begin
						for (int i = 0; i < held_count; i++)
							queue_result(result_of(held_lits[i][VAR_W:1],
								held_lits[i][0], i == held_count - 1, 1'b0, clause_ovf));
					end
					held_count = 0;
					clause_sat = 1'b0;
					clause_ovf = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input res_word_t got);
		res_word_t want;
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result word var %0d neg %0b last %0b %s %0b %s %0b",
					$realtime, got.out_var, got.out_negated, got.run_last, "empty",
					got.empty_clause, "long", got.too_long);
		end else begin
			want = due_results.pop_front();
			checked++;
			if (got.out_var !== want.out_var || got.out_negated !== want.out_negated ||
					got.run_last !== want.run_last || got.empty_clause !== want.empty_clause ||
					got.too_long !== want.too_long) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected var %0d neg %0b last %0b empty %0b long %0b",
						want.out_var, want.out_negated, want.run_last, want.empty_clause,
						want.too_long);
					$display("  actual   var %0d neg %0b last %0b empty %0b long %0b",
						got.out_var, got.out_negated, got.run_last, got.empty_clause,
						got.too_long);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) check_result(res_word);
			if (req_valid && !req_stall) condition_word(req_word);
			pending = due_results.size();
		end
	end

endmodule

FILE: bench/cnf_clause_conditioning_test.sv
`timescale 1ns / 100ps
// Top of the testbench for the CNF clause conditioning block: clock, reset, request
// stimulus, result-side stalls and the verdict. Depends on cnfc_pkg, the block itself
// and cnfc_result_checker.
module cnf_clause_conditioning_test;
	import cnfc_pkg::*;

	localparam int NUM_VARS     = NUM_VARS_DEF;
	localparam int MAX_LEN      = MAX_CLAUSE_LEN_DEF;
	localparam int ITEMS_TOTAL  = 360;
	localparam int CHOKE_CYCLES = 400;
	localparam int TAIL_CYCLES  = 200;
	// The slowest correct run is dominated by the table sweeps: one after reset and at
	// most four clears. On top of that come roughly 420 words and at most about 1000
	// result words, each waiting out the longest gap or stall, plus the long hold-off.
	// LIMIT_CYCLES leaves ample margin above that sum.
	localparam int LIMIT_CYCLES = 3000000;

	// The block leaves this request code unused and must ignore it.
	localparam logic [1:0] REQ_SPARE = 2'd3;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req_word  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_word_t res_word;

	int mismatches;
	int pending;
	int checked;

	// Words by kind as they were accepted. Ignored words are the spare code and
	// units with variable zero.
	int n_units   = 0;
	int n_lits    = 0;
	int n_clauses = 0;
	int n_clears  = 0;
	int n_ignored = 0;

	// When quiet is set neither side idles, but for a requested hold-off. Each increment
	// of choke_asks asks the receiver for one long hold-off.
	bit quiet      = 1'b0;
	int choke_asks = 0;
	int cycle_count = 0;

	always #6 clk = ~clk;

	cnf_clause_conditioning #(
		.NUM_VARS       (NUM_VARS),
		.MAX_CLAUSE_LEN (MAX_LEN)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	cnfc_result_checker #(
		.NUM_VARS (NUM_VARS),
		.MAX_LEN  (MAX_LEN)
	) CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_word   (req_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	// Watchdog. A hang anywhere, including a sweep that never ends, lands here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d result words outstanding",
				cycle_count, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Most variables come from a small pool so that units and clause literals meet.
	// The rest sweep the top of the range, the whole range, and the invalid zero.
	function automatic logic [VAR_W-1:0] pick_var();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return '0;
		if (r < 70) return VAR_W'($urandom_range(1, 24));
		if (r < 85) return VAR_W'($urandom_range(65520, 65535));
		return VAR_W'($urandom_range(1, 65535));
	endfunction

	// Short clauses dominate; a few reach the buffer size and a few overflow it.
	function automatic int clause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 5);
		if (r < 93) return $urandom_range(6, 12);
		if (r < 98) return $urandom_range(13, MAX_LEN);
		return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
	endfunction

	function automatic req_word_t word_of(logic [1:0] kind, logic [VAR_W-1:0] v, logic n,
			logic last);
		req_word_t w;
		w.req_type   = kind;
		w.var_index  = v;
		w.negated    = n;
		w.clause_end = last;
		return w;
	endfunction

	// Offers one word at a falling edge, holds it until the block takes it, then
	// idles for a random gap unless a quiet stretch is running.
	task automatic offer(input req_word_t w);
		int gap;
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (req_stall !== 1'b0);
		case (w.req_type)
			REQ_UNIT: begin
				if (w.var_index == '0) n_ignored++;
				else n_units++;
			end
			REQ_LIT: begin
				n_lits++;
				if (w.clause_end) n_clauses++;
			end
			REQ_CLEAR: n_clears++;
			default: n_ignored++;
		endcase
		@(negedge clk);
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// The sender stops offering until every predicted result word has arrived.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// A well-formed clause with random literals. Now and then a unit slips in
	// between literals, which must change the verdict only for later literals.
	task automatic random_clause(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 6)
				offer(word_of(REQ_UNIT, pick_var(), 1'($urandom_range(0, 1)), 1'b0));
			offer(word_of(REQ_LIT, pick_var(), 1'($urandom_range(0, 1)), i == len - 1));
		end
	endtask

	// Result side. A requested hold-off wins over everything; otherwise the stall
	// runs in random stretches, or not at all during a quiet stretch.
	initial begin
		int  run_left;
		int  choke_left;
		int  chokes_seen;
		bit  stalling;
		run_left    = 0;
		choke_left  = 0;
		chokes_seen = 0;
		stalling    = 1'b0;
		forever begin
			@(negedge clk);
			if (choke_left > 0) begin
				res_stall <= 1'b1;
				choke_left--;
			end else if (chokes_seen != choke_asks) begin
				chokes_seen = choke_asks;
				choke_left  = CHOKE_CYCLES - 1;
				res_stall  <= 1'b1;
			end else if (quiet) begin
				res_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stalling = $urandom_range(0, 99) < 35;
					run_left = stalling ? pick_gap() + 1 : $urandom_range(1, 8);
				end
				run_left--;
				res_stall <= stalling;
			end
		end
	end

	// Request side and verdict.
	initial begin
		int r;
		int segment_left;
		int clears_left;
		segment_left = 0;
		clears_left  = 3;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words. The first ones wait out the table sweep after reset.
		// Units at both ends of the variable range, and one with the invalid zero.
		offer(word_of(REQ_UNIT, 16'hFFFF, 1'b0, 1'b0));
		offer(word_of(REQ_UNIT, 16'd1, 1'b1, 1'b1));
		offer(word_of(REQ_UNIT, 16'd0, 1'b0, 1'b0));
		// Every literal contradicts the table, so the clause comes out empty.
		offer(word_of(REQ_LIT, 16'hFFFF, 1'b1, 1'b0));
		offer(word_of(REQ_LIT, 16'd1, 1'b0, 1'b1));
		// Satisfied in the middle: the buffered literal and the tail are dropped.
		offer(word_of(REQ_LIT, 16'd2, 1'b0, 1'b0));
		offer(word_of(REQ_LIT, 16'hFFFF, 1'b0, 1'b0));
		offer(word_of(REQ_LIT, 16'd3, 1'b1, 1'b1));
		// A literal on variable zero counts as unassigned and is echoed.
		offer(word_of(REQ_LIT, 16'd0, 1'b1, 1'b1));
		// A unit inside a clause: the literal already buffered keeps its place, the
		// later literal on the same variable is now false.
		offer(word_of(REQ_LIT, 16'd100, 1'b0, 1'b0));
		offer(word_of(REQ_UNIT, 16'd100, 1'b1, 1'b0));
		offer(word_of(REQ_LIT, 16'd101, 1'b1, 1'b0));
		offer(word_of(REQ_LIT, 16'd100, 1'b0, 1'b1));
		// A clear inside a clause wipes the table but not the clause.
		offer(word_of(REQ_LIT, 16'd200, 1'b0, 1'b0));
		offer(word_of(REQ_CLEAR, 16'd0, 1'b0, 1'b0));
		offer(word_of(REQ_LIT, 16'hFFFF, 1'b1, 1'b1));
		// The unused request code.
		offer(word_of(REQ_SPARE, 16'hA5A5, 1'b1, 1'b1));
		// A repeated unit: the second polarity wins and satisfies the clause.
		offer(word_of(REQ_UNIT, 16'd5, 1'b0, 1'b0));
		offer(word_of(REQ_UNIT, 16'd5, 1'b1, 1'b0));
		offer(word_of(REQ_LIT, 16'd5, 1'b1, 1'b1));
		drain();

		// Back pressure: the receiver holds off for a long stretch while the sender
		// keeps going with an overflowing clause and two short ones, so the output
		// register fills and the block has to stall its input.
		quiet = 1'b1;
		choke_asks++;
		for (int i = 0; i < MAX_LEN + 4; i++)
			offer(word_of(REQ_LIT, VAR_W'(40000 + i), 1'($urandom_range(0, 1)),
				i == MAX_LEN + 3));
		for (int k = 0; k < 2; k++)
			for (int i = 0; i < 4; i++)
				offer(word_of(REQ_LIT, VAR_W'(41000 + 8 * k + i), 1'($urandom_range(0, 1)),
					i == 3));
		quiet = 1'b0;
		drain();

		// Random part, in segments that are either quiet or idle at random.
		while (n_units + n_lits + n_clears < ITEMS_TOTAL) begin
			if (segment_left == 0) begin
				segment_left = $urandom_range(20, 50);
				quiet = $urandom_range(0, 99) < 20;
			end
			segment_left--;
			r = $urandom_range(0, 999);
			if (r < 560) begin
				random_clause(clause_len());
			end else if (r < 900) begin
				offer(word_of(REQ_UNIT, pick_var(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
			end else if (r < 940) begin
				offer(word_of(REQ_SPARE, VAR_W'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			end else if (r < 955 && clears_left > 0) begin
				clears_left--;
				offer(word_of(REQ_CLEAR, VAR_W'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			end else if (r < 975) begin
				drain();
			end else begin
				// A clause left open: its literals run on into the next clause.
				offer(word_of(REQ_LIT, pick_var(), 1'($urandom_range(0, 1)), 1'b0));
			end
		end

		drain();
		quiet = 1'b1;
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d units, %0d clause literals in %0d clauses, %0d clears, %0d ignored words.",
			n_units, n_lits, n_clauses, n_clears, n_ignored);
		$display("Checked %0d result words: %0d mismatches, %0d never arrived.",
			checked, mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
design/cnfc_pkg.sv
design/cnfc_ram.sv
design/cnfc_ctrl.sv
design/cnfc_dp.sv
design/cnf_clause_conditioning.sv
design/cnfc_checker.sv
bench/cnfc_result_checker.sv
bench/cnf_clause_conditioning_test.sv
